@@ hw/rtl/rtp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rtp_pkg
// Shared types, constants and the per-character token parse step for the
// ringtone note parser.
// ----------------------------------------------------------------------------
package rtp_pkg;

  // field widths
  localparam int CHAR_W   = 8;
  localparam int FREQ_W   = 16;
  localparam int DUR_W    = 19;
  localparam int TONE_W   = 4;
  localparam int OCT_W    = 3;
  localparam int ACC_W    = 8;
  localparam int DDUR_W   = 7;
  localparam int BPM_W    = 10;
  localparam int PROD_W   = BPM_W + ACC_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_DUR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_OCT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BPM     = 2'd2;

  // configuration reset values
  localparam logic [DDUR_W-1:0] DEF_DUR_RST = 7'd4;
  localparam logic [OCT_W-1:0]  DEF_OCT_RST = 3'd5;
  localparam logic [BPM_W-1:0]  BPM_RST     = 10'd63;

  // whole-note length numerators in ms, plain and dotted
  localparam logic [DUR_W-1:0] DUR_NUM_PLAIN  = 19'd240000;
  localparam logic [DUR_W-1:0] DUR_NUM_DOTTED = 19'd360000;

  localparam logic [OCT_W-1:0]  OCT_MIN   = 3'd4;
  localparam logic [TONE_W-1:0] TONE_REST = 4'd7;
  localparam logic [TONE_W-1:0] TONE_B    = 4'd1;
  localparam logic [TONE_W-1:0] TONE_SHARP = 4'd8;
  localparam logic [ACC_W-1:0]  ACC_MAX   = 8'd255;

  // character codes
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_BAR   = 8'h7C;
  localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_4     = 8'h34;
  localparam logic [CHAR_W-1:0] CH_7     = 8'h37;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_G  = 8'h67;
  localparam logic [CHAR_W-1:0] CH_LO_H  = 8'h68;
  localparam logic [CHAR_W-1:0] CASE_BIT = 8'h20;

  // token parse phase
  typedef enum logic [6:0] {
    PH_SKIP   = 7'b0000001,
    PH_DUR    = 7'b0000010,
    PH_LETTER = 7'b0000100,
    PH_SHARP  = 7'b0001000,
    PH_DOT1   = 7'b0010000,
    PH_OCT    = 7'b0100000,
    PH_TRAIL  = 7'b1000000
  } phase_t;

  typedef struct packed {
    phase_t             phase;
    logic [ACC_W-1:0]   acc;
    logic [TONE_W-1:0]  tone;
    logic [OCT_W-1:0]   oct;
    logic               dotted;
  } parse_t;

  typedef struct packed {
    parse_t nxt;
    parse_t note;
    logic   emit_note;
    logic   emit_end;
  } step_t;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  localparam parse_t PARSE_INIT = '{phase: PH_SKIP, acc: '0, tone: '0, oct: '0,
                                    dotted: 1'b0};

  // pitch in tenths of hertz at octave 4, sharps in the upper half
  function automatic logic [FREQ_W-1:0] pitch_of(logic [TONE_W-1:0] tone);
    logic [FREQ_W-1:0] p;
    case (tone)
      4'd0:    p = 16'd4400;
      4'd1:    p = 16'd4939;
      4'd2:    p = 16'd2616;
      4'd3:    p = 16'd2937;
      4'd4:    p = 16'd3296;
      4'd5:    p = 16'd3492;
      4'd6:    p = 16'd3920;
      4'd8:    p = 16'd4662;
      4'd10:   p = 16'd2772;
      4'd11:   p = 16'd3111;
      4'd13:   p = 16'd3700;
      4'd14:   p = 16'd4153;
      default: p = '0;
    endcase
    return p;
  endfunction

  // note letter to tone index, either case, anything else a rest
  function automatic logic [TONE_W-1:0] letter_tone(logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] lc;
    logic [CHAR_W-1:0] ofs;
    logic [TONE_W-1:0] t;
    lc  = (c >= CH_UP_A && c <= CH_UP_Z) ? (c | CASE_BIT) : c;
    ofs = lc - CH_LO_A;
    if (lc >= CH_LO_A && lc <= CH_LO_G) t = ofs[TONE_W-1:0];
    else if (lc == CH_LO_H) t = TONE_B;
    else t = TONE_REST;
    return t;
  endfunction

  // one character through the token parser
  function automatic step_t parse_step(parse_t s, logic [CHAR_W-1:0] c,
                                       logic [OCT_W-1:0] def_oct);
    step_t             r;
    parse_t            w;
    logic              is_digit;
    logic              live;
    logic [ACC_W+3:0]  v;
    w        = s;
    live     = 1'b0;
    is_digit = (c >= CH_0) && (c <= CH_9);
    v        = ({4'b0, s.acc} << 3) + ({4'b0, s.acc} << 1) + {8'b0, c[3:0]};
    r.emit_note = 1'b0;
    r.emit_end  = 1'b0;
    unique case (s.phase) inside
      PH_SKIP: begin
        if (c == CH_SPACE || c == CH_COMMA) begin
          w = s;
        end else if (c == CH_BAR) begin
          r.emit_end = 1'b1;
        end else if (is_digit) begin
          w.acc   = {4'b0, c[3:0]};
          w.phase = PH_DUR;
        end else begin
          w.tone  = letter_tone(c);
          w.phase = PH_LETTER;
        end
      end
      PH_DUR: begin
        if (is_digit) begin
          w.acc = (v > {4'b0, ACC_MAX}) ? ACC_MAX : v[ACC_W-1:0];
        end else begin
          w.tone  = letter_tone(c);
          w.phase = PH_LETTER;
        end
      end
      PH_LETTER, PH_SHARP, PH_DOT1, PH_OCT, PH_TRAIL: begin
        live = 1'b1;
        // optional sharp
        if (w.phase == PH_LETTER) begin
          if (c == CH_HASH) begin
            w.tone  = w.tone + TONE_SHARP;
            w.phase = PH_SHARP;
            live    = 1'b0;
          end else begin
            w.phase = PH_SHARP;
          end
        end
        // optional dot before the octave
        if (live && w.phase == PH_SHARP) begin
          if (c == CH_DOT) begin
            w.dotted = 1'b1;
            w.phase  = PH_DOT1;
            live     = 1'b0;
          end else begin
            w.phase = PH_DOT1;
          end
        end
        // optional octave digit, else the default
        if (live && w.phase == PH_DOT1) begin
          w.phase = PH_OCT;
          if (c >= CH_4 && c <= CH_7) begin
            w.oct = c[OCT_W-1:0];
            live  = 1'b0;
          end else begin
            w.oct = (def_oct < OCT_MIN) ? OCT_MIN : def_oct;
          end
        end
        // optional trailing dot
        if (live && w.phase == PH_OCT && c == CH_DOT) begin
          w.dotted = 1'b1;
          w.phase  = PH_TRAIL;
          live     = 1'b0;
        end
        // swallowed character closes the token
        if (live) r.emit_note = 1'b1;
      end
      default: w = PARSE_INIT;
    endcase
    r.note = w;
    r.nxt  = r.emit_note ? PARSE_INIT : w;
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/rtp_chan_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rtp channel interfaces
// Valid/ready channels for tune characters, notes and register writes.
// ----------------------------------------------------------------------------

// tune character channel
interface rtp_in_if;
  logic                       valid;
  logic                       ready;
  logic [rtp_pkg::CHAR_W-1:0] char_code;
  logic                       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// note result channel
interface rtp_out_if;
  logic                       valid;
  logic                       ready;
  logic [rtp_pkg::FREQ_W-1:0] frequency_decihertz;
  logic [rtp_pkg::DUR_W-1:0]  duration_ms;
  logic [rtp_pkg::TONE_W-1:0] tone_index;
  logic [rtp_pkg::OCT_W-1:0]  octave_used;
  logic                       end_of_tune;

  modport source (output valid, output frequency_decihertz, output duration_ms,
                  output tone_index, output octave_used, output end_of_tune,
                  input ready);
  modport sink   (input valid, input frequency_decihertz, input duration_ms,
                  input tone_index, input octave_used, input end_of_tune,
                  output ready);
endinterface

// register write channel
interface rtp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rtp_pkg::CFG_IDX_W-1:0]  index;
  logic [rtp_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/rtp_divider.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rtp_divider
// Restoring radix-2 divider, one quotient bit per cycle, for note lengths.
// ----------------------------------------------------------------------------
module rtp_divider (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [rtp_pkg::DUR_W-1:0]   dividend,
  input  wire logic [rtp_pkg::PROD_W-1:0]  divisor,
  output rtp_pkg::div_stat_t               stat,
  output logic      [rtp_pkg::DUR_W-1:0]   quotient
);

  localparam int QW    = rtp_pkg::DUR_W;
  localparam int DW    = rtp_pkg::PROD_W;
  localparam int CNT_W = $clog2(QW + 1);

  logic [DW-1:0]    rem_r, rem_nxt;
  logic [QW-1:0]    quo_r, quo_nxt;
  logic [DW-1:0]    dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DW:0]      shifted;
  logic [DW:0]      diff;
  logic             fits;

  // one shift-subtract step
  always_comb begin
    shifted  = {rem_r, quo_r[QW-1]};
    diff     = shifted - {1'b0, dvs_r};
    fits     = shifted >= {1'b0, dvs_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = CNT_W'(QW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[DW-1:0] : shifted[DW-1:0];
      quo_nxt = {quo_r[QW-2:0], fits};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

  // done is a single pulse after the last step
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while still busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("divider done held longer than one cycle");

  a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != '0)
    else $error("divider busy with an empty step count");

endmodule
`default_nettype wire

@@ hw/rtl/ringtone_note_parser_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ringtone_note_parser_core
// Tune body parser: one character per item in, one note or end marker out.
// ----------------------------------------------------------------------------
// note path: parse step, divider load, divide steps, done pulse, output load;
//   an end marker goes from the parse step to the output load
// intake: a character is taken only once the last is parsed and any result
//   pushed; a final character adds up to 3 flush steps with bar characters
// reset: synchronous active-low rst_n clears parser, sequencer and registers
//   to their defaults (duration 4, octave 5, tempo 63)

module ringtone_note_parser_core (
  input wire logic  clk,
  input wire logic  rst_n,
  rtp_in_if.sink    in_chan,
  rtp_out_if.source out_chan,
  rtp_cfg_if.sink   cfg_chan
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_FEED = 5'b00010,
    S_MUL  = 5'b00100,
    S_DIV  = 5'b01000,
    S_PUSH = 5'b10000
  } fsm_t;

  fsm_t                          state_r, state_nxt;
  rtp_pkg::parse_t               parse_r, parse_nxt;
  rtp_pkg::parse_t               note_r, note_nxt;
  logic [rtp_pkg::CHAR_W-1:0]    char_r, char_nxt;
  logic                          tail_r, tail_nxt;
  logic                          res_end_r, res_end_nxt;
  rtp_pkg::step_t                step;

  logic [rtp_pkg::DDUR_W-1:0]    def_dur_r;
  logic [rtp_pkg::OCT_W-1:0]     def_oct_r;
  logic [rtp_pkg::BPM_W-1:0]     bpm_r;

  logic                          out_valid_r, out_valid_nxt;
  logic [rtp_pkg::FREQ_W-1:0]    out_freq_r;
  logic [rtp_pkg::DUR_W-1:0]     out_dur_r;
  logic [rtp_pkg::TONE_W-1:0]    out_tone_r;
  logic [rtp_pkg::OCT_W-1:0]     out_oct_r;
  logic                          out_end_r;

  logic                          push_go;
  logic                          div_start;
  logic [rtp_pkg::ACC_W-1:0]     dur_eff;
  logic [rtp_pkg::BPM_W-1:0]     bpm_eff;
  logic [rtp_pkg::PROD_W-1:0]    divisor;
  logic [rtp_pkg::DUR_W-1:0]     dividend;
  logic [rtp_pkg::OCT_W-1:0]     oct_eff;
  logic [rtp_pkg::FREQ_W-1:0]    pitch_scaled;
  rtp_pkg::div_stat_t            div_stat;
  logic [rtp_pkg::DUR_W-1:0]     div_q;

  // register writes, always accepted
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      def_dur_r <= rtp_pkg::DEF_DUR_RST;
      def_oct_r <= rtp_pkg::DEF_OCT_RST;
      bpm_r     <= rtp_pkg::BPM_RST;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        rtp_pkg::CFG_DEF_DUR: def_dur_r <= cfg_chan.data[rtp_pkg::DDUR_W-1:0];
        rtp_pkg::CFG_DEF_OCT: def_oct_r <= cfg_chan.data[rtp_pkg::OCT_W-1:0];
        rtp_pkg::CFG_BPM:     bpm_r     <= cfg_chan.data[rtp_pkg::BPM_W-1:0];
        default: ;
      endcase
    end
  end

  // parse step on the held character
  assign step = rtp_pkg::parse_step(parse_r, char_r, def_oct_r);

  // note length operands: zero duration and zero tempo fall back
  always_comb begin
    if (note_r.acc != '0) dur_eff = note_r.acc;
    else if (def_dur_r != '0) dur_eff = {1'b0, def_dur_r};
    else dur_eff = rtp_pkg::ACC_W'(1);
    bpm_eff  = (bpm_r != '0) ? bpm_r : rtp_pkg::BPM_W'(1);
    divisor  = rtp_pkg::PROD_W'(bpm_eff) * rtp_pkg::PROD_W'(dur_eff);
    dividend = note_r.dotted ? rtp_pkg::DUR_NUM_DOTTED : rtp_pkg::DUR_NUM_PLAIN;
  end

  assign div_start = (state_r == S_MUL);

  rtp_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // pitch scaled by octave
  always_comb begin
    oct_eff      = (note_r.oct < rtp_pkg::OCT_MIN) ? rtp_pkg::OCT_MIN : note_r.oct;
    pitch_scaled = rtp_pkg::pitch_of(note_r.tone) << oct_eff[1:0];
  end

  assign push_go = (state_r == S_PUSH) && (!out_valid_r || out_chan.ready);

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    parse_nxt   = parse_r;
    note_nxt    = note_r;
    char_nxt    = char_r;
    tail_nxt    = tail_r;
    res_end_nxt = res_end_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          char_nxt  = in_chan.char_code;
          tail_nxt  = in_chan.last_char;
          state_nxt = S_FEED;
        end
      end
      S_FEED: begin
        parse_nxt = step.nxt;
        char_nxt  = rtp_pkg::CH_BAR;
        if (step.emit_note) begin
          note_nxt    = step.note;
          res_end_nxt = 1'b0;
          state_nxt   = S_MUL;
        end else if (step.emit_end) begin
          res_end_nxt = 1'b1;
          tail_nxt    = 1'b0;
          state_nxt   = S_PUSH;
        end else if (!tail_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_MUL: state_nxt = S_DIV;
      S_DIV: begin
        if (div_stat.done) state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (push_go) state_nxt = tail_r ? S_FEED : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (push_go) out_valid_nxt = 1'b1;
    else if (out_chan.ready) out_valid_nxt = 1'b0;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      parse_r     <= rtp_pkg::PARSE_INIT;
      tail_r      <= 1'b0;
      res_end_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      parse_r     <= parse_nxt;
      tail_r      <= tail_nxt;
      res_end_r   <= res_end_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    note_r <= note_nxt;
    char_r <= char_nxt;
    if (push_go) begin
      out_end_r  <= res_end_r;
      out_freq_r <= res_end_r ? '0 : pitch_scaled;
      out_dur_r  <= res_end_r ? '0 : div_q;
      out_tone_r <= res_end_r ? '0 : note_r.tone;
      out_oct_r  <= res_end_r ? '0 : oct_eff;
    end
  end

  assign in_chan.ready                = (state_r == S_IDLE);
  assign out_chan.valid               = out_valid_r;
  assign out_chan.frequency_decihertz = out_freq_r;
  assign out_chan.duration_ms         = out_dur_r;
  assign out_chan.tone_index          = out_tone_r;
  assign out_chan.octave_used         = out_oct_r;
  assign out_chan.end_of_tune         = out_end_r;

  // divider runs only under the note sequence
  a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !div_stat.busy)
    else $error("divider busy while parser idle");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == S_DIV)
    else $error("divider finished outside the divide step");

  // an end marker closes the item
  a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (push_go && res_end_r) |=> (state_r == S_IDLE && !tail_r))
    else $error("parsing went on after an end marker");

  // a note leaves the parser back between tokens
  a_note_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FEED && step.emit_note) |=> parse_r.phase == rtp_pkg::PH_SKIP)
    else $error("parser not cleared after a note");

endmodule
`default_nettype wire

@@ sim/ringtone_note_parser_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ringtone_note_parser_core_tb
// Feeds tune text one character per item, with register writes between
// phases, and checks every note and end marker against a predictor of the
// token parser. Both channels idle at random in all but the last three phases.
// ----------------------------------------------------------------------------

module ringtone_note_parser_core_tb;

  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 64;
  localparam int PHASES       = 9;
  localparam int CHARS_PER_PHASE = 165;

  typedef struct packed {
    logic [rtp_pkg::CHAR_W-1:0] code;
    logic                       last;
  } tune_char_t;

  typedef struct packed {
    logic [rtp_pkg::FREQ_W-1:0] freq;
    logic [rtp_pkg::DUR_W-1:0]  ms;
    logic [rtp_pkg::TONE_W-1:0] tone;
    logic [rtp_pkg::OCT_W-1:0]  oct;
    logic                       eot;
  } note_t;

  logic clk;
  logic rst_n;

  rtp_in_if  in_chan ();
  rtp_out_if out_chan ();
  rtp_cfg_if cfg_chan ();

  ringtone_note_parser_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  tune_char_t pending_chars[$];
  note_t      expected_notes[$];
  int         fail_count = 0;
  int         stall_cycles = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  logic       in_taken = 1'b0;

  // register copies
  logic [rtp_pkg::DDUR_W-1:0] def_dur_reg = rtp_pkg::DEF_DUR_RST;
  logic [rtp_pkg::OCT_W-1:0]  def_oct_reg = rtp_pkg::DEF_OCT_RST;
  logic [rtp_pkg::BPM_W-1:0]  tempo_reg   = rtp_pkg::BPM_RST;

  // token parser state
  rtp_pkg::phase_t            tok_phase  = rtp_pkg::PH_SKIP;
  logic [rtp_pkg::ACC_W-1:0]  dur_acc    = '0;
  logic [rtp_pkg::TONE_W-1:0] tok_tone   = '0;
  logic [rtp_pkg::OCT_W-1:0]  tok_oct    = '0;
  logic                       tok_dotted = 1'b0;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // pitch at octave 4 in tenths of hertz, zero for rests and missing sharps
  function automatic logic [rtp_pkg::FREQ_W-1:0] tone_pitch(
      logic [rtp_pkg::TONE_W-1:0] t);
    case (t)
      4'd0:    return 16'd4400;
      4'd1:    return 16'd4939;
      4'd2:    return 16'd2616;
      4'd3:    return 16'd2937;
      4'd4:    return 16'd3296;
      4'd5:    return 16'd3492;
      4'd6:    return 16'd3920;
      4'd8:    return 16'd4662;
      4'd10:   return 16'd2772;
      4'd11:   return 16'd3111;
      4'd13:   return 16'd3700;
      4'd14:   return 16'd4153;
      default: return 16'd0;
    endcase
  endfunction

  // letter to tone, either case, h is b, anything else a rest
  function automatic logic [rtp_pkg::TONE_W-1:0] tone_of_letter(
      logic [rtp_pkg::CHAR_W-1:0] c);
    logic [rtp_pkg::CHAR_W-1:0] lc;
    lc = (c >= rtp_pkg::CH_UP_A && c <= rtp_pkg::CH_UP_Z) ? (c | rtp_pkg::CASE_BIT) : c;
    if (lc >= rtp_pkg::CH_LO_A && lc <= rtp_pkg::CH_LO_G)
      return rtp_pkg::TONE_W'(lc - rtp_pkg::CH_LO_A);
    if (lc == rtp_pkg::CH_LO_H) return rtp_pkg::TONE_B;
    return rtp_pkg::TONE_REST;
  endfunction

  // at most two results per character
  task automatic emit_result(note_t r, inout int n);
    if (n < 2) begin
      expected_notes.push_back(r);
      n++;
    end
  endtask

  // note from the open token, parser back to skipping
  task automatic close_note(inout int n);
    int unsigned len_div;
    int unsigned tempo;
    int unsigned octave;
    int unsigned numer;
    note_t       r;
    len_div = dur_acc;
    if (len_div == 0) len_div = (def_dur_reg != 0) ? def_dur_reg : 1;
    tempo  = (tempo_reg != 0) ? tempo_reg : 1;
    octave = (tok_oct < rtp_pkg::OCT_MIN) ? rtp_pkg::OCT_MIN : tok_oct;
    numer  = tok_dotted ? 360000 : 240000;
    r.freq = tone_pitch(tok_tone) << (octave - 4);
    r.ms   = rtp_pkg::DUR_W'(numer / (tempo * len_div));
    r.tone = tok_tone;
    r.oct  = rtp_pkg::OCT_W'(octave);
    r.eot  = 1'b0;
    emit_result(r, n);
    tok_phase  = rtp_pkg::PH_SKIP;
    dur_acc    = '0;
    tok_tone   = '0;
    tok_oct    = '0;
    tok_dotted = 1'b0;
  endtask

  // one character through the token parser
  task automatic parse_char(logic [rtp_pkg::CHAR_W-1:0] c, inout int n,
                            output bit ended);
    bit          is_digit;
    bit          open;
    int unsigned v;
    note_t       marker;
    ended    = 1'b0;
    is_digit = (c >= rtp_pkg::CH_0) && (c <= rtp_pkg::CH_9);
    if (tok_phase == rtp_pkg::PH_SKIP) begin
      if (c == rtp_pkg::CH_SPACE || c == rtp_pkg::CH_COMMA) begin
        // separator between tokens
      end else if (c == rtp_pkg::CH_BAR) begin
        marker     = '0;
        marker.eot = 1'b1;
        emit_result(marker, n);
        ended = 1'b1;
      end else if (is_digit) begin
        dur_acc   = rtp_pkg::ACC_W'(c - rtp_pkg::CH_0);
        tok_phase = rtp_pkg::PH_DUR;
      end else begin
        tok_tone  = tone_of_letter(c);
        tok_phase = rtp_pkg::PH_LETTER;
      end
    end else if (tok_phase == rtp_pkg::PH_DUR) begin
      if (is_digit) begin
        v       = dur_acc * 32'd10 + 32'(c - rtp_pkg::CH_0);
        dur_acc = (v > rtp_pkg::ACC_MAX) ? rtp_pkg::ACC_MAX : rtp_pkg::ACC_W'(v);
      end else begin
        tok_tone  = tone_of_letter(c);
        tok_phase = rtp_pkg::PH_LETTER;
      end
    end else begin
      open = 1'b1;
      // optional sharp
      if (tok_phase == rtp_pkg::PH_LETTER) begin
        tok_phase = rtp_pkg::PH_SHARP;
        if (c == rtp_pkg::CH_HASH) begin
          tok_tone = tok_tone + rtp_pkg::TONE_SHARP;
          open     = 1'b0;
        end
      end
      // optional dot before the octave
      if (open && tok_phase == rtp_pkg::PH_SHARP) begin
        tok_phase = rtp_pkg::PH_DOT1;
        if (c == rtp_pkg::CH_DOT) begin
          tok_dotted = 1'b1;
          open       = 1'b0;
        end
      end
      // octave digit or the default
      if (open && tok_phase == rtp_pkg::PH_DOT1) begin
        tok_phase = rtp_pkg::PH_OCT;
        if (c >= rtp_pkg::CH_4 && c <= rtp_pkg::CH_7) begin
          tok_oct = c[rtp_pkg::OCT_W-1:0];
          open    = 1'b0;
        end else begin
          tok_oct = (def_oct_reg < rtp_pkg::OCT_MIN) ? rtp_pkg::OCT_MIN : def_oct_reg;
        end
      end
      // optional trailing dot
      if (open && tok_phase == rtp_pkg::PH_OCT && c == rtp_pkg::CH_DOT) begin
        tok_dotted = 1'b1;
        tok_phase  = rtp_pkg::PH_TRAIL;
        open       = 1'b0;
      end
      // swallowed character closes the token
      if (open) close_note(n);
    end
  endtask

  task automatic match_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // prediction, checking and watchdog at the rising edge
  always @(posedge clk) begin : monitor
    int    n;
    bit    ended;
    note_t want;
    if (rst_n) begin
      in_taken <= in_chan.valid && in_chan.ready;
      // register writes
      if (cfg_chan.valid && cfg_chan.ready) begin
        case (cfg_chan.index)
          rtp_pkg::CFG_DEF_DUR: def_dur_reg = cfg_chan.data[rtp_pkg::DDUR_W-1:0];
          rtp_pkg::CFG_DEF_OCT: def_oct_reg = cfg_chan.data[rtp_pkg::OCT_W-1:0];
          rtp_pkg::CFG_BPM:     tempo_reg   = cfg_chan.data[rtp_pkg::BPM_W-1:0];
          default: ;
        endcase
      end
      // accepted character, a final one flushes with bars
      if (in_chan.valid && in_chan.ready) begin
        n = 0;
        parse_char(in_chan.char_code, n, ended);
        if (in_chan.last_char && !ended) begin
          for (int i = 0; i < 4 && !ended; i++) parse_char(rtp_pkg::CH_BAR, n, ended);
        end
      end
      // accepted result against the oldest expectation
      if (out_chan.valid && out_chan.ready) begin
        if (expected_notes.size() == 0) begin
          $error("unexpected result: freq %0d ms %0d tone %0d oct %0d end %0b",
                 out_chan.frequency_decihertz, out_chan.duration_ms,
                 out_chan.tone_index, out_chan.octave_used, out_chan.end_of_tune);
          fail_count++;
        end else begin
          want = expected_notes.pop_front();
          match_field("frequency_decihertz", want.freq, out_chan.frequency_decihertz);
          match_field("duration_ms", want.ms, out_chan.duration_ms);
          match_field("tone_index", want.tone, out_chan.tone_index);
          match_field("octave_used", want.oct, out_chan.octave_used);
          match_field("end_of_tune", want.eot, out_chan.end_of_tune);
        end
      end
      // watchdog on cycles without any handshake
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
          (cfg_chan.valid && cfg_chan.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("FAIL ringtone_note_parser_core");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // character driver and result backpressure at the falling edge
  always @(negedge clk) begin : driver
    tune_char_t nxt;
    if (!rst_n) begin
      in_chan.valid  <= 1'b0;
      out_chan.ready <= 1'b0;
    end else begin
      if (!in_chan.valid || in_taken) begin
        if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_chars.pop_front();
          in_chan.valid     <= 1'b1;
          in_chan.char_code <= nxt.code;
          in_chan.last_char <= nxt.last;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
      out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic push_char(logic [rtp_pkg::CHAR_W-1:0] c, logic last);
    tune_char_t t;
    t.code = c;
    t.last = last;
    pending_chars.push_back(t);
  endtask

  function automatic logic rare_last();
    return $urandom_range(99) < 2;
  endfunction

  // one token, mostly well formed, sometimes plain noise
  task automatic queue_token();
    string                      letters;
    int unsigned                roll;
    int unsigned                val;
    logic [rtp_pkg::CHAR_W-1:0] c;
    letters = "abcdefghp";
    roll = $urandom_range(99);
    if (roll < 8) begin
      repeat ($urandom_range(1, 4))
        push_char(rtp_pkg::CHAR_W'($urandom_range(255)), rare_last());
      return;
    end
    // separators, now and then a bar
    repeat ($urandom_range(2))
      push_char($urandom_range(1) ? rtp_pkg::CH_SPACE : rtp_pkg::CH_COMMA, rare_last());
    if ($urandom_range(99) < 5) push_char(rtp_pkg::CH_BAR, rare_last());
    // duration: none, a usual divisor, or random digits
    roll = $urandom_range(99);
    if (roll >= 40 && roll < 85) begin
      val = 1 << $urandom_range(6);
      if (val >= 10) push_char(rtp_pkg::CH_0 + rtp_pkg::CHAR_W'(val / 10), rare_last());
      push_char(rtp_pkg::CH_0 + rtp_pkg::CHAR_W'(val % 10), rare_last());
    end else if (roll >= 85) begin
      repeat ($urandom_range(1, 4))
        push_char(rtp_pkg::CH_0 + rtp_pkg::CHAR_W'($urandom_range(9)), rare_last());
    end
    // letter in either case, or any byte
    if ($urandom_range(99) < 85) begin
      c = letters[$urandom_range(8)];
      if ($urandom_range(1)) c = c & ~rtp_pkg::CASE_BIT;
    end else begin
      c = rtp_pkg::CHAR_W'($urandom_range(255));
    end
    push_char(c, rare_last());
    if ($urandom_range(99) < 35) push_char(rtp_pkg::CH_HASH, rare_last());
    if ($urandom_range(99) < 20) push_char(rtp_pkg::CH_DOT, rare_last());
    if ($urandom_range(99) < 60) begin
      if ($urandom_range(99) < 85)
        push_char(rtp_pkg::CH_4 + rtp_pkg::CHAR_W'($urandom_range(3)), rare_last());
      else
        push_char(rtp_pkg::CH_0 + rtp_pkg::CHAR_W'($urandom_range(9)), rare_last());
    end
    if ($urandom_range(99) < 20) push_char(rtp_pkg::CH_DOT, rare_last());
    // swallowed character
    roll = $urandom_range(99);
    if (roll < 70) push_char(rtp_pkg::CH_COMMA, rare_last());
    else if (roll < 85) push_char(rtp_pkg::CH_SPACE, rare_last());
    else push_char(rtp_pkg::CHAR_W'($urandom_range(255)), rare_last());
  endtask

  task automatic write_register(logic [rtp_pkg::CFG_IDX_W-1:0] idx,
                                logic [rtp_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= val;
    do @(posedge clk); while (!(cfg_chan.valid && cfg_chan.ready));
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  // phases: register settings, directed text, random tokens, drain
  initial begin
    string       directed;
    int unsigned dd;
    int unsigned dov;
    int unsigned bpm;
    rst_n              = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.char_code  = '0;
    in_chan.last_char  = 1'b0;
    out_chan.ready     = 1'b0;
    cfg_chan.valid     = 1'b0;
    cfg_chan.index     = rtp_pkg::CFG_DEF_DUR;
    cfg_chan.data      = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph / 3)
        0: begin send_idle_pct = 16; recv_idle_pct = 46; end
        1: begin send_idle_pct = 46; recv_idle_pct = 16; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase

      if (ph != 0) begin
        case (ph)
          1: begin dd = 1;   dov = 4; bpm = 1;    end
          2: begin dd = 64;  dov = 7; bpm = 900;  end
          3: begin dd = 0;   dov = 0; bpm = 0;    end
          4: begin dd = 127; dov = 3; bpm = 1023; end
          5: begin
            dd  = $urandom_range(1, 64);
            dov = $urandom_range(4, 7);
            bpm = $urandom_range(1, 900);
          end
          default: begin
            dd  = $urandom_range(127);
            dov = $urandom_range(7);
            bpm = $urandom_range(1023);
          end
        endcase
        write_register(rtp_pkg::CFG_DEF_DUR, rtp_pkg::CFG_DATA_W'(dd));
        write_register(rtp_pkg::CFG_DEF_OCT, rtp_pkg::CFG_DATA_W'(dov));
        write_register(rtp_pkg::CFG_BPM, rtp_pkg::CFG_DATA_W'(bpm));
      end

      // saturating duration, sharp with a dot, zero duration, mid-tune bar,
      // rest after digits, high byte as the swallowed character, sharp with
      // no pitch, null byte closing the tune
      if (ph == 0) begin
        directed = "999G#4. 0c.7.,|8 \377e#5,";
        for (int i = 0; i < directed.len(); i++) push_char(directed[i], 1'b0);
        push_char(8'h00, 1'b1);
      end

      while (pending_chars.size() < CHARS_PER_PHASE) queue_token();
      pending_chars[pending_chars.size() - 1].last = 1'b1;

      wait (pending_chars.size() == 0 && !in_chan.valid);
      wait (expected_notes.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clk);
    end

    if (fail_count == 0) begin
      $display("PASS ringtone_note_parser_core");
    end else begin
      $display("FAIL ringtone_note_parser_core");
    end
    $finish;
  end

endmodule

@@ ringtone_note_parser_core.f @@
hw/rtl/rtp_pkg.sv
hw/rtl/rtp_chan_if.sv
hw/rtl/rtp_divider.sv
hw/rtl/ringtone_note_parser_core.sv
sim/ringtone_note_parser_core_tb.sv
